>>> design/g3rb_pkg.sv
// ----------------------------------------------------------------------------
// g3rb_pkg: shared types and constants of the 3x3 Gaussian filter
// Pixel column type for the window cells, result group for the output queue,
// register indexes and fixed sizes.
// ----------------------------------------------------------------------------
package g3rb_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int LS_W       = 2 * PIX_W;
    localparam int GRP_DEPTH  = 4;
    localparam int GRP_AW     = $clog2(GRP_DEPTH);
    localparam int GRP_CW     = $clog2(GRP_DEPTH + 1);
    localparam int NUM_RES    = 4;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic shift;
        logic fill;
    } t_cell_ctl;

    typedef struct packed {
        logic [NUM_RES-1:0][PIX_W-1:0] pix;
        logic [NUM_RES-1:0]            mask;
    } t_grp;

endpackage

>>> design/g3rb_line_store.sv
// ----------------------------------------------------------------------------
// g3rb_line_store: line memory for the two previous rows
// One write port and one registered read port; each entry holds the pixel of
// row r-2 in the upper byte and of row r-1 in the lower byte.
// ----------------------------------------------------------------------------
module g3rb_line_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [g3rb_pkg::LS_W-1:0]   i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [g3rb_pkg::LS_W-1:0]   o_rdata
);

    logic [g3rb_pkg::LS_W-1:0] r_mem [DEPTH];
    logic [g3rb_pkg::LS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/g3rb_col_cell.sv
// ----------------------------------------------------------------------------
// g3rb_col_cell: one column of the 3x3 window
// Holds three pixels; shifts in its right neighbor's column, or the new
// column when a row starts.
// ----------------------------------------------------------------------------
module g3rb_col_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  g3rb_pkg::t_cell_ctl   i_ctl,
    input  g3rb_pkg::t_col        i_new,
    input  g3rb_pkg::t_col        i_next,
    output g3rb_pkg::t_col        o_col
);

    g3rb_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctl.shift) begin
            r_col <= i_ctl.fill ? i_new : i_next;
        end
    end

    assign o_col = r_col;

endmodule

>>> design/g3rb_kernel.sv
// ----------------------------------------------------------------------------
// g3rb_kernel: weighted 3x3 sum
// Corners times 16, edge neighbors times 31, center times 67, scaled by 1/256.
// ----------------------------------------------------------------------------
module g3rb_kernel (
    input  g3rb_pkg::t_col                  i_left,
    input  g3rb_pkg::t_col                  i_centre,
    input  g3rb_pkg::t_col                  i_right,
    output logic [g3rb_pkg::PIX_W-1:0]      o_pix
);

    logic [9:0]  w_corners;
    logic [9:0]  w_edges;
    logic [15:0] w_corner_term;
    logic [15:0] w_edge_term;
    logic [15:0] w_centre_term;
    logic [15:0] w_sum;

    assign w_corners = 10'(i_left.top) + 10'(i_right.top)
                     + 10'(i_left.bot) + 10'(i_right.bot);
    assign w_edges   = 10'(i_centre.top) + 10'(i_left.mid)
                     + 10'(i_right.mid) + 10'(i_centre.bot);

    assign w_corner_term = 16'({w_corners, 4'b0000});
    assign w_edge_term   = 16'({w_edges, 5'b00000}) - 16'(w_edges);
    assign w_centre_term = 16'({i_centre.mid, 6'b000000}) + 16'({i_centre.mid, 1'b0})
                         + 16'(i_centre.mid);

    assign w_sum = w_corner_term + w_edge_term + w_centre_term;
    assign o_pix = w_sum[15:8];

endmodule

>>> design/gaussian_3x3_replicate_border.sv
// ----------------------------------------------------------------------------
// gaussian_3x3_replicate_border: streaming 3x3 Gaussian blur, replicated border
// Raster-order pixels in, smoothed pixels out one row and one pixel later.
//
//   channel  | direction | transfer                 | payload
//   s axis   | in        | tvalid & tready          | tdata[7:0] pixel_in
//   m axis   | out       | tvalid & tready          | tdata[7:0] pixel_out,
//            |           |                          | tlast frame_end, tuser run_last
//   cfg      | in        | i_cfg_wr_en              | index 0 width, 1 height
//
// One input pixel per cycle while each pixel yields at most one result and
// the output does not stall; a pixel yielding several results holds the
// output port until all are sent, and the four-entry result queue then
// pauses input. Reset is synchronous and clears counters, window and queue;
// the line stores need no clearing. Both sides may stall freely; tready on
// the input depends only on registered state.
// ----------------------------------------------------------------------------
module gaussian_3x3_replicate_border #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_index,
    input  logic [g3rb_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,    // [7:0] pixel_in
    // output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,    // [7:0] pixel_out
    output logic                           o_m_tlast,    // frame_end
    output logic                           o_m_tuser     // [0] run_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > g3rb_pkg::CFG_W) ? CW + 1 : g3rb_pkg::CFG_W;
    localparam int PW = g3rb_pkg::PIX_W;
    localparam int HW = g3rb_pkg::CFG_W;

    // configuration
    logic [HW-1:0] r_width;
    logic [HW-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= g3rb_pkg::WIDTH_RESET;
            r_height <= g3rb_pkg::HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                g3rb_pkg::REG_WIDTH:  r_width  <= i_cfg_wdata;
                g3rb_pkg::REG_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // position counters
    logic [CW-1:0]              r_col;
    logic [g3rb_pkg::ROW_W-1:0] r_row;
    logic [WW-1:0]              w_wreq;
    logic [WW-1:0]              w_weff;
    logic [HW-1:0]              w_heff;
    logic                       w_last_col;
    logic                       w_last_row;
    logic                       w_in_acc;

    assign w_wreq = WW'(r_width);

    always_comb begin
        if (w_wreq == '0) begin
            w_weff = WW'(1);
        end else if (w_wreq > WW'(MAX_WIDTH)) begin
            w_weff = WW'(MAX_WIDTH);
        end else begin
            w_weff = w_wreq;
        end
        if (r_height == '0) begin
            w_heff = HW'(1);
        end else if (r_height > HW'(g3rb_pkg::MAX_HEIGHT)) begin
            w_heff = HW'(g3rb_pkg::MAX_HEIGHT);
        end else begin
            w_heff = r_height;
        end
    end

    assign w_last_col = (WW'(r_col) + WW'(1)) >= w_weff;
    assign w_last_row = ({1'b0, r_row} + HW'(1)) >= w_heff;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_in_acc) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage 1: line store read
    logic                           r_s1_valid;
    logic [PW-1:0]                  r_s1_px;
    logic [CW-1:0]                  r_s1_addr;
    logic                           r_s1_fill;
    logic                           r_s1_rge1;
    logic                           r_s1_rge2;
    logic [g3rb_pkg::NUM_RES-1:0]   r_s1_mask;
    logic                           r_fwd;
    logic [g3rb_pkg::LS_W-1:0]      r_fwd_data;
    logic [g3rb_pkg::LS_W-1:0]      w_rdata;
    logic [g3rb_pkg::LS_W-1:0]      w_line;
    logic [g3rb_pkg::LS_W-1:0]      w_ls_wdata;
    logic [PW-1:0]                  w_up;
    logic [PW-1:0]                  w_mid;
    logic                           w_cge1;

    assign w_cge1 = r_col != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
            r_fwd      <= w_in_acc && r_s1_valid && (r_s1_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_ls_wdata;
        if (w_in_acc) begin
            r_s1_px   <= i_s_tdata;
            r_s1_addr <= r_col;
            r_s1_fill <= !w_cge1;
            r_s1_rge1 <= r_row != '0;
            r_s1_rge2 <= r_row[g3rb_pkg::ROW_W-1:1] != '0;
            r_s1_mask <= {w_last_row && w_last_col, w_last_row && w_cge1,
                          (r_row != '0) && w_last_col, (r_row != '0) && w_cge1};
        end
    end

    g3rb_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (w_ls_wdata),
        .i_re    (w_in_acc),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    assign w_line     = r_fwd ? r_fwd_data : w_rdata;
    assign w_up       = w_line[g3rb_pkg::LS_W-1:PW];
    assign w_mid      = w_line[PW-1:0];
    assign w_ls_wdata = {w_mid, r_s1_px};

    // stage 2: window cells
    g3rb_pkg::t_col      w_new;
    g3rb_pkg::t_col      w_win [3];
    g3rb_pkg::t_cell_ctl w_ctl;

    assign w_new.top = r_s1_rge2 ? w_up : (r_s1_rge1 ? w_mid : r_s1_px);
    assign w_new.mid = r_s1_rge1 ? w_mid : r_s1_px;
    assign w_new.bot = r_s1_px;
    assign w_ctl.shift = r_s1_valid;
    assign w_ctl.fill  = r_s1_fill;

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_cell
            g3rb_col_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_new   (w_new),
                .i_next  ((gi == 2) ? w_new : w_win[(gi == 2) ? 2 : gi + 1]),
                .o_col   (w_win[gi])
            );
        end
    endgenerate

    logic                         r_s2_valid;
    logic [g3rb_pkg::NUM_RES-1:0] r_s2_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mask <= r_s1_mask;
    end

    // filter taps: full window, right border, bottom border, corner
    g3rb_pkg::t_col w_lo0;
    g3rb_pkg::t_col w_lo1;
    g3rb_pkg::t_col w_lo2;
    logic [PW-1:0]  w_f [g3rb_pkg::NUM_RES];

    assign w_lo0 = '{top: w_win[0].mid, mid: w_win[0].bot, bot: w_win[0].bot};
    assign w_lo1 = '{top: w_win[1].mid, mid: w_win[1].bot, bot: w_win[1].bot};
    assign w_lo2 = '{top: w_win[2].mid, mid: w_win[2].bot, bot: w_win[2].bot};

    g3rb_kernel u_k0 (.i_left(w_win[0]), .i_centre(w_win[1]), .i_right(w_win[2]),
                      .o_pix(w_f[0]));
    g3rb_kernel u_k1 (.i_left(w_win[1]), .i_centre(w_win[2]), .i_right(w_win[2]),
                      .o_pix(w_f[1]));
    g3rb_kernel u_k2 (.i_left(w_lo0), .i_centre(w_lo1), .i_right(w_lo2),
                      .o_pix(w_f[2]));
    g3rb_kernel u_k3 (.i_left(w_lo1), .i_centre(w_lo2), .i_right(w_lo2),
                      .o_pix(w_f[3]));

    // result group queue
    g3rb_pkg::t_grp                r_fifo [g3rb_pkg::GRP_DEPTH];
    logic [g3rb_pkg::GRP_AW-1:0]   r_wr;
    logic [g3rb_pkg::GRP_AW-1:0]   r_rd;
    logic [g3rb_pkg::GRP_CW-1:0]   r_cnt;
    logic [g3rb_pkg::NUM_RES-1:0]  r_sent;
    logic                          w_push;
    logic                          w_pop;
    logic                          w_out_acc;
    g3rb_pkg::t_grp                w_grp;
    g3rb_pkg::t_grp                w_head;
    logic [g3rb_pkg::NUM_RES-1:0]  w_rem;
    logic [g3rb_pkg::NUM_RES-1:0]  w_cur;
    logic                          w_last;
    logic [g3rb_pkg::GRP_CW:0]     w_load;

    assign w_grp.pix  = {w_f[3], w_f[2], w_f[1], w_f[0]};
    assign w_grp.mask = r_s2_mask;
    assign w_push     = r_s2_valid && (r_s2_mask != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr] <= w_grp;
        end
    end

    assign w_head    = r_fifo[r_rd];
    assign w_rem     = w_head.mask & ~r_sent;
    assign w_cur     = w_rem & (~w_rem + 1'b1);
    assign w_last    = (w_rem & (w_rem - 1'b1)) == '0;
    assign w_out_acc = o_m_tvalid && i_m_tready;
    assign w_pop     = w_out_acc && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
            r_sent <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_out_acc) begin
                if (w_last) begin
                    r_rd   <= r_rd + 1'b1;
                    r_sent <= '0;
                end else begin
                    r_sent <= r_sent | w_cur;
                end
            end
            r_cnt <= r_cnt + g3rb_pkg::GRP_CW'(w_push) - g3rb_pkg::GRP_CW'(w_pop);
        end
    end

    assign w_load     = {1'b0, r_cnt} + (g3rb_pkg::GRP_CW + 1)'(r_s1_valid)
                      + (g3rb_pkg::GRP_CW + 1)'(r_s2_valid);
    assign o_s_tready = w_load < (g3rb_pkg::GRP_CW + 1)'(g3rb_pkg::GRP_DEPTH);

    always_comb begin
        case (w_cur)
            4'b0001: o_m_tdata = w_head.pix[0];
            4'b0010: o_m_tdata = w_head.pix[1];
            4'b0100: o_m_tdata = w_head.pix[2];
            4'b1000: o_m_tdata = w_head.pix[3];
            default: o_m_tdata = '0;
        endcase
    end

    assign o_m_tvalid = r_cnt != '0;
    assign o_m_tlast  = w_cur[3];
    assign o_m_tuser  = w_last;

    // checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load <= (g3rb_pkg::GRP_CW + 1)'(g3rb_pkg::GRP_DEPTH))
        else $error("result queue over its depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> $onehot(w_cur))
        else $error("queued group has no pending result");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser)
        else $error("frame end not on last result of its transaction");

    a_fwd_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_s1_valid && $past(r_s1_valid)))
        else $error("line forward without a preceding write");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for gaussian_3x3_replicate_border
// Streams pixel frames of many sizes through the filter and compares each
// smoothed pixel, frame-end flag and run-last flag against a predictor that
// keeps its own line stores, 3x3 window and row/column position. Covers
// one-pixel frames, full-scale pixels, widths and heights cut short mid-frame,
// clamped register values and random frames with random back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_DEPTH  = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int IDLE_PCT    = 29;
    localparam int RANDOM_PIX  = 460;

    typedef struct packed {
        logic [g3rb_pkg::PIX_W-1:0] pixel;
        logic                       frame_end;
        logic                       run_last;
    } t_blur_out;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic                       i_cfg_index = g3rb_pkg::REG_WIDTH;
    logic [g3rb_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                       i_s_tvalid  = 1'b0;
    logic                       o_s_tready;
    logic [7:0]                 i_s_tdata   = '0;
    logic                       o_m_tvalid;
    logic                       i_m_tready  = 1'b0;
    logic [7:0]                 o_m_tdata;
    logic                       o_m_tlast;
    logic                       o_m_tuser;

    // predictor state
    bit [g3rb_pkg::PIX_W-1:0]   upper_line  [LINE_DEPTH];
    bit [g3rb_pkg::PIX_W-1:0]   middle_line [LINE_DEPTH];
    bit [g3rb_pkg::PIX_W-1:0]   win [3][3];    // [left, center, right][top, middle, bottom]
    int unsigned                row_pos;
    int unsigned                col_pos;
    logic [g3rb_pkg::CFG_W-1:0] width_reg;
    logic [g3rb_pkg::CFG_W-1:0] height_reg;

    t_blur_out        blur_expected[$];
    bit               steady;
    int unsigned      cycles;
    int unsigned      errors;
    int unsigned      pixels_sent;
    int unsigned      results_checked;
    int unsigned      frames_closed;

    gaussian_3x3_replicate_border #(
        .MAX_WIDTH(LINE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, blur_expected.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // compare every output transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_blur_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_checked++;
            if (o_m_tlast) frames_closed++;
            if (blur_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result pixel %0d", o_m_tdata));
            end else begin
                want = blur_expected.pop_front();
                if (o_m_tdata !== want.pixel)
                    report_mismatch($sformatf("result %0d pixel %0d, expected %0d",
                                              results_checked, o_m_tdata, want.pixel));
                if (o_m_tlast !== want.frame_end)
                    report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                              results_checked, o_m_tlast, want.frame_end));
                if (o_m_tuser !== want.run_last)
                    report_mismatch($sformatf("result %0d run_last %b, expected %b",
                                              results_checked, o_m_tuser, want.run_last));
            end
        end
    end

    function automatic logic [g3rb_pkg::PIX_W-1:0] blur_at(
        input int cl, input int cc, input int cr,
        input int rt, input int rm, input int rb);
        int unsigned corners;
        int unsigned edges;
        int unsigned total;
        corners = win[cl][rt] + win[cr][rt] + win[cl][rb] + win[cr][rb];
        edges   = win[cc][rt] + win[cl][rm] + win[cr][rm] + win[cc][rb];
        total   = 16 * corners + 31 * edges + 67 * win[cc][rm];
        return g3rb_pkg::PIX_W'(total >> 8);
    endfunction

    function automatic void predict_pixel(input logic [g3rb_pkg::PIX_W-1:0] px);
        int unsigned              w;
        int unsigned              h;
        int unsigned              r;
        int unsigned              c;
        bit [g3rb_pkg::PIX_W-1:0] a;
        bit [g3rb_pkg::PIX_W-1:0] b;
        bit                       last_col;
        bit                       last_row;
        t_blur_out                run[$];
        w = (width_reg == 0) ? 1 : int'(width_reg);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h > g3rb_pkg::MAX_HEIGHT) h = g3rb_pkg::MAX_HEIGHT;
        r = row_pos;
        c = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);

        // replicate the top border: missing rows take the nearest row
        a = (r >= 2) ? upper_line[c] : ((r >= 1) ? middle_line[c] : px);
        b = (r >= 1) ? middle_line[c] : px;
        upper_line[c]  = middle_line[c];
        middle_line[c] = px;

        if (c == 0) begin
            for (int i = 0; i < 3; i++) begin
                win[i][0] = a;
                win[i][1] = b;
                win[i][2] = px;
            end
        end else begin
            for (int j = 0; j < 3; j++) begin
                win[0][j] = win[1][j];
                win[1][j] = win[2][j];
            end
            win[2][0] = a;
            win[2][1] = b;
            win[2][2] = px;
        end

        if (r >= 1) begin
            if (c >= 1) run.push_back('{blur_at(0, 1, 2, 0, 1, 2), 1'b0, 1'b0});
            if (last_col) run.push_back('{blur_at(1, 2, 2, 0, 1, 2), 1'b0, 1'b0});
        end
        if (last_row) begin
            if (c >= 1) run.push_back('{blur_at(0, 1, 2, 1, 2, 2), 1'b0, 1'b0});
            if (last_col) run.push_back('{blur_at(1, 2, 2, 1, 2, 2), 1'b1, 1'b0});
        end
        if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
        foreach (run[k]) blur_expected.push_back(run[k]);

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic send_pixel(input logic [g3rb_pkg::PIX_W-1:0] px);
        int idle;
        idle = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) idle++;
        end
        if (idle > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_pixel(px);
        pixels_sent++;
    endtask

    // hold input until every expected result has come, then let the pipe empty
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (blur_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [g3rb_pkg::CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == g3rb_pkg::REG_WIDTH) width_reg = val;
        else height_reg = val;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [g3rb_pkg::PIX_W-1:0] random_pixel();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return g3rb_pkg::PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic test_one_pixel_frames();
        settle();
        write_reg(g3rb_pkg::REG_WIDTH, '0);
        write_reg(g3rb_pkg::REG_HEIGHT, '0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h80);
    endtask

    task automatic test_full_scale_pixels();
        settle();
        write_reg(g3rb_pkg::REG_WIDTH, 13'd3);
        write_reg(g3rb_pkg::REG_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
    endtask

    // start a row at the clamped maximum width, then shrink it past the column
    task automatic test_row_cut_from_max_width();
        settle();
        write_reg(g3rb_pkg::REG_WIDTH, '1);
        write_reg(g3rb_pkg::REG_HEIGHT, 13'd2);
        for (int i = 0; i < 4; i++) send_pixel(random_pixel());
        settle();
        write_reg(g3rb_pkg::REG_WIDTH, 13'd2);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
    endtask

    task automatic test_frame_cut_from_max_height();
        settle();
        write_reg(g3rb_pkg::REG_WIDTH, 13'd1);
        write_reg(g3rb_pkg::REG_HEIGHT, '1);
        for (int i = 0; i < 3; i++) send_pixel(random_pixel());
        settle();
        write_reg(g3rb_pkg::REG_HEIGHT, 13'd2);
        send_pixel(8'hFF);
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned sent;
        int unsigned in_frame;
        int unsigned cut_at;
        bit          cut;
        sent = 0;
        while (sent < RANDOM_PIX) begin
            steady = (sent >= 150 && sent < 260);
            settle();
            case ($urandom_range(0, 9))
                0:       w = 1;
                1:       w = 2;
                2:       w = $urandom_range(20, 48);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
            write_reg(g3rb_pkg::REG_WIDTH, g3rb_pkg::CFG_W'(w));
            write_reg(g3rb_pkg::REG_HEIGHT, g3rb_pkg::CFG_W'(h));
            cut = (w * h > 1) && ($urandom_range(0, 4) == 0);
            cut_at = (w * h > 1) ? $urandom_range(1, w * h - 1) : 0;
            in_frame = 0;
            do begin
                send_pixel(random_pixel());
                sent++;
                in_frame++;
                if (cut && in_frame == cut_at) begin
                    settle();
                    // shrink only, so no line-store entry is read before it is written
                    if ($urandom_range(0, 1))
                        write_reg(g3rb_pkg::REG_HEIGHT,
                                  g3rb_pkg::CFG_W'($urandom_range(1, h)));
                    else
                        write_reg(g3rb_pkg::REG_WIDTH,
                                  g3rb_pkg::CFG_W'($urandom_range(1, w)));
                end
            end while (!(row_pos == 0 && col_pos == 0));
        end
        steady = 1'b0;
    endtask

    initial begin
        width_reg  = g3rb_pkg::WIDTH_RESET;
        height_reg = g3rb_pkg::HEIGHT_RESET;
        row_pos    = 0;
        col_pos    = 0;
        steady     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_one_pixel_frames();
        test_full_scale_pixels();
        test_row_cut_from_max_width();
        test_frame_cut_from_max_height();
        test_random_frames();
        settle();

        $display("sent %0d pixels, checked %0d smoothed pixels over %0d frames",
                 pixels_sent, results_checked, frames_closed);
        $display("sizes from 1x1 to clamped maximum, with row and frame cuts, %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
